### rtl/fpls_pkg.sv
// ----------------------------------------------------------------------------
// fpls_pkg
// Shared constants and types for the five-point laplacian stencil core.
// ----------------------------------------------------------------------------
package fpls_pkg;

    localparam int MAX_COLS_DEF    = 1024;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int MAX_BORDER      = 4;
    localparam int MAX_ROWS        = 4096;

    localparam int CFG_W       = 13;
    localparam int CFG_IDX_W   = 2;
    localparam int ROWS_W      = 13;
    localparam int RAW_COLS_W  = 11;
    localparam int BORDER_W    = 3;
    localparam int OUT_ROW_W   = 12;
    localparam int OUT_COL_W   = 10;

    // stencil weight of the centre cell is 4, applied as a shift
    localparam int WEIGHT_SHIFT = 2;

    localparam int QUEUE_DEPTH = 3;
    localparam int QUEUE_CNT_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROWS   = 2'd0,
        REG_COLS   = 2'd1,
        REG_BORDER = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic                   not_empty;
        logic [QUEUE_CNT_W-1:0] count;
    } queue_stat_t;

endpackage

### rtl/fpls_line_buf.sv
// ----------------------------------------------------------------------------
// fpls_line_buf
// Line buffer memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module fpls_line_buf
    import fpls_pkg::*;
#(
    parameter int DEPTH  = MAX_COLS_DEF + 2 * MAX_BORDER,
    parameter int DATA_W = 2 * SAMPLE_BITS_DEF
) (
    input  logic                     aclk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data
);

    logic [DATA_W-1:0] line_mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            line_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= line_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/fpls_res_queue.sv
// ----------------------------------------------------------------------------
// fpls_res_queue
// Small result queue in front of the output channel.
// ----------------------------------------------------------------------------
module fpls_res_queue
    import fpls_pkg::*;
#(
    parameter int DATA_W = SAMPLE_BITS_DEF + 3 + OUT_ROW_W + OUT_COL_W + 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DATA_W-1:0] out_data,
    output queue_stat_t       stat
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    logic [DATA_W-1:0]      entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg;
    logic [PTR_W-1:0]       rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic                   pop;

    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && out_ready;
    assign out_data  = entry_reg[rd_ptr_reg];

    assign stat.not_empty = out_valid;
    assign stat.count     = count_reg;

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

### rtl/five_point_laplacian_stencil_core.sv
// ----------------------------------------------------------------------------
// five_point_laplacian_stencil_core
// Streams a bordered grid in raster order and gives 4*centre minus the four
// neighbours for every interior cell, tagged with row, column and last flag.
//
//   channel  direction  payload                                        
//   cfg      in         cfg_we, cfg_index, cfg_wdata                   
//   s_       in         s_cell_value                                   
//   m_       out        m_laplacian, m_out_row, m_out_col, m_last_of_grid
//
// one item per cycle sustained while s_ready is high; the line buffer is read when an
// item is taken and written back in the next cycle at the same address.
// the cell that completes a window yields its result in the second stage.
// a three-entry result queue absorbs output stalls; input ready drops when
// the queue plus the item in flight could fill it.
// reset is synchronous; the line buffer needs no clearing pass.
// ----------------------------------------------------------------------------
module five_point_laplacian_stencil_core
    import fpls_pkg::*;
#(
    parameter int MAX_COLS    = MAX_COLS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_W-1:0]            cfg_wdata,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_cell_value,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [SAMPLE_BITS+2:0] m_laplacian,
    output logic [OUT_ROW_W-1:0]        m_out_row,
    output logic [OUT_COL_W-1:0]        m_out_col,
    output logic                        m_last_of_grid
);

    localparam int LINE_LEN = MAX_COLS + 2 * MAX_BORDER;
    localparam int X_W      = $clog2(LINE_LEN);
    localparam int XC_W     = X_W + 1;
    localparam int YC_W     = ROWS_W + 1;
    localparam int COL_W    = $clog2(MAX_COLS + 1);
    localparam int RES_W    = SAMPLE_BITS + 3;
    localparam int MEM_W    = 2 * SAMPLE_BITS;
    localparam int Q_W      = RES_W + OUT_ROW_W + OUT_COL_W + 1;

    // configuration, held as clamped effective values
    logic [ROWS_W-1:0]     rows_reg;
    logic [COL_W-1:0]      cols_reg;
    logic [BORDER_W-1:0]   border_reg;
    logic [ROWS_W-1:0]     rows_next;
    logic [COL_W-1:0]      cols_next;
    logic [BORDER_W-1:0]   border_next;
    logic [RAW_COLS_W-1:0] cols_raw;
    logic [BORDER_W-1:0]   border_raw;

    assign cols_raw   = cfg_wdata[RAW_COLS_W-1:0];
    assign border_raw = cfg_wdata[BORDER_W-1:0];

    always_comb begin
        if (cfg_wdata == '0) begin
            rows_next = ROWS_W'(1);
        end else if (cfg_wdata > CFG_W'(MAX_ROWS)) begin
            rows_next = ROWS_W'(MAX_ROWS);
        end else begin
            rows_next = cfg_wdata[ROWS_W-1:0];
        end
        if (cols_raw == '0) begin
            cols_next = COL_W'(1);
        end else if (int'(cols_raw) > MAX_COLS) begin
            cols_next = COL_W'(MAX_COLS);
        end else begin
            cols_next = COL_W'(cols_raw);
        end
        if (border_raw == '0) begin
            border_next = BORDER_W'(1);
        end else if (border_raw > BORDER_W'(MAX_BORDER)) begin
            border_next = BORDER_W'(MAX_BORDER);
        end else begin
            border_next = border_raw;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg   <= ROWS_W'(1);
            cols_reg   <= COL_W'(1);
            border_reg <= BORDER_W'(1);
        end else if (cfg_we) begin
            case (cfg_reg_t'(cfg_index))
                REG_ROWS:   rows_reg   <= rows_next;
                REG_COLS:   cols_reg   <= cols_next;
                REG_BORDER: border_reg <= border_next;
                default: ;
            endcase
        end
    end

    // position counters and the decode of the incoming cell
    logic [X_W-1:0]    x_reg;
    logic [ROWS_W-1:0] y_reg;
    logic [XC_W-1:0]   x_ext, b_x, cols_x, width_x, k_full;
    logic [YC_W-1:0]   y_ext, b_y, rows_y, height_y, r_full;
    logic              x_wrap, y_wrap, in_x, in_y, cell_last;
    logic              accept;

    assign x_ext    = XC_W'(x_reg);
    assign b_x      = XC_W'(border_reg);
    assign cols_x   = XC_W'(cols_reg);
    assign width_x  = cols_x + (b_x << 1);
    assign y_ext    = YC_W'(y_reg);
    assign b_y      = YC_W'(border_reg);
    assign rows_y   = YC_W'(rows_reg);
    assign height_y = rows_y + (b_y << 1);

    assign x_wrap    = (x_ext + 1'b1) >= width_x;
    assign y_wrap    = (y_ext + 1'b1) >= height_y;
    assign in_x      = (x_ext >= b_x + 1'b1) && (x_ext < b_x + 1'b1 + cols_x);
    assign in_y      = (y_ext >= b_y + 1'b1) && (y_ext < b_y + 1'b1 + rows_y);
    assign k_full    = x_ext - b_x - 1'b1;
    assign r_full    = y_ext - b_y - 1'b1;
    assign cell_last = (r_full == rows_y - 1'b1) && (k_full == cols_x - 1'b1);

    assign accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_reg <= '0;
            y_reg <= '0;
        end else if (accept) begin
            if (x_wrap) begin
                x_reg <= '0;
                y_reg <= y_wrap ? '0 : y_reg + 1'b1;
            end else begin
                x_reg <= x_reg + 1'b1;
            end
        end
    end

    // second stage: line buffer data arrives, window shifts, result computed
    logic                          s1_valid_reg;
    logic                          s1_emit_reg;
    logic                          s1_last_reg;
    logic [OUT_ROW_W-1:0]          s1_row_reg;
    logic [OUT_COL_W-1:0]          s1_col_reg;
    logic [X_W-1:0]                s1_addr_reg;
    logic signed [SAMPLE_BITS-1:0] s1_bot_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_emit_reg <= in_x && in_y;
            s1_last_reg <= cell_last;
            s1_row_reg  <= r_full[OUT_ROW_W-1:0];
            s1_col_reg  <= k_full[OUT_COL_W-1:0];
            s1_addr_reg <= x_reg;
            s1_bot_reg  <= s_cell_value;
        end
    end

    logic [MEM_W-1:0]              rd_word;
    logic signed [SAMPLE_BITS-1:0] top_cell, mid_cell;

    fpls_line_buf #(
        .DEPTH  (LINE_LEN),
        .DATA_W (MEM_W)
    ) u_line_buf (
        .aclk    (aclk),
        .rd_en   (accept),
        .rd_addr (x_reg),
        .rd_data (rd_word),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_addr_reg),
        .wr_data ({mid_cell, s1_bot_reg})
    );

    // word layout: upper half is the row two above, lower half the row above
    assign top_cell = rd_word[MEM_W-1:SAMPLE_BITS];
    assign mid_cell = rd_word[SAMPLE_BITS-1:0];

    // window: column x-2 middle, column x-1 top, middle, bottom
    logic signed [SAMPLE_BITS-1:0] left_mid_reg;
    logic signed [SAMPLE_BITS-1:0] ctr_top_reg;
    logic signed [SAMPLE_BITS-1:0] ctr_mid_reg;
    logic signed [SAMPLE_BITS-1:0] ctr_bot_reg;
    logic signed [RES_W-1:0]       lap;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_mid_reg <= '0;
            ctr_top_reg  <= '0;
            ctr_mid_reg  <= '0;
            ctr_bot_reg  <= '0;
        end else if (s1_valid_reg) begin
            left_mid_reg <= ctr_mid_reg;
            ctr_top_reg  <= top_cell;
            ctr_mid_reg  <= mid_cell;
            ctr_bot_reg  <= s1_bot_reg;
        end
    end

    assign lap = (RES_W'(ctr_mid_reg) <<< WEIGHT_SHIFT) - RES_W'(ctr_top_reg)
               - RES_W'(ctr_bot_reg) - RES_W'(left_mid_reg) - RES_W'(mid_cell);

    // result queue
    logic [Q_W-1:0]  q_out;
    queue_stat_t     q_stat;
    logic [QUEUE_CNT_W:0] occupancy;

    fpls_res_queue #(
        .DATA_W (Q_W)
    ) u_res_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s1_valid_reg && s1_emit_reg),
        .push_data ({lap, s1_row_reg, s1_col_reg, s1_last_reg}),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (q_out),
        .stat      (q_stat)
    );

    // room for the item in flight plus one more
    assign occupancy = (QUEUE_CNT_W + 1)'(q_stat.count) + (QUEUE_CNT_W + 1)'(s1_valid_reg);
    assign s_ready   = occupancy <= (QUEUE_CNT_W + 1)'(QUEUE_DEPTH - 1);

    assign m_laplacian    = q_out[Q_W-1 -: RES_W];
    assign m_out_row      = q_out[OUT_COL_W + 1 +: OUT_ROW_W];
    assign m_out_col      = q_out[1 +: OUT_COL_W];
    assign m_last_of_grid = q_out[0];

    a_stage_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> s1_valid_reg)
        else $error("accepted item did not reach second stage");

    a_queue_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && s1_emit_reg) |-> (q_stat.count != QUEUE_CNT_W'(QUEUE_DEPTH)))
        else $error("result pushed into full queue");

    a_col_range: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(x_reg) < LINE_LEN)
        else $error("column position beyond line buffer");

    a_valid_matches_stat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid == q_stat.not_empty)
        else $error("output valid disagrees with queue status");

endmodule
